// ===== design/wrps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrps_pkg
// Shared constants and stage payload types of the weighted port selector.
// ----------------------------------------------------------------------------
package wrps_pkg;

  localparam int unsigned NUM_COST = 5;   // ports that carry a cost field
  localparam int unsigned PORT_W   = 3;
  localparam int unsigned COST_W   = 8;
  localparam int unsigned RND_W    = 31;
  localparam int unsigned SCALE    = 100;

  localparam int unsigned WT_W  = 7;                   // weight 0..SCALE
  localparam int unsigned SUM_W = 11;                  // sum of (cost+1)
  localparam int unsigned REM_W = SUM_W + WT_W - 1;    // divider remainder
  localparam int unsigned TOT_W = 9;                   // weight total

  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = (WT_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned MOD_STEPS  = 8;
  localparam int unsigned MOD_STAGES = (RND_W + MOD_STEPS - 1) / MOD_STEPS;

  typedef logic [NUM_COST-1:0] pmask_t;

  // Decision state that travels with a request.
  typedef struct packed {
    pmask_t              present;
    pmask_t              vcok;
    logic                decided;
    logic [PORT_W-1:0]   port;
    logic                no_choice;
  } ctl_t;

  typedef struct packed {
    ctl_t                             ctl;
    logic [RND_W-1:0]                 rnd;
    logic [SUM_W-1:0]                 sum;
    logic [NUM_COST-1:0][REM_W-1:0]   rem;
    logic [NUM_COST-1:0][WT_W-1:0]    wt;
    logic [TOT_W-1:0]                 total;
  } divw_t;

  typedef struct packed {
    ctl_t                             ctl;
    logic [RND_W-1:0]                 rnd;
    logic [NUM_COST-1:0][WT_W-1:0]    wt;
    logic [TOT_W-1:0]                 total;
    logic [TOT_W-1:0]                 rem;
  } modw_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              no_choice;
  } res_t;

endpackage
`default_nettype wire

// ===== design/wrps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrps_front
// Masks the candidates, forms the scaled costs and their sum, and settles
// the cases that need no draw.
// ----------------------------------------------------------------------------
module wrps_front #(
  parameter int unsigned USE_PORTS = 5
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst_n,
  input  wire logic                                            in_valid,
  output logic                                                 in_ready,
  input  wire logic [wrps_pkg::NUM_COST-1:0]                   in_present,
  input  wire logic [wrps_pkg::NUM_COST-1:0]                   in_vc,
  input  wire logic [wrps_pkg::NUM_COST-1:0][wrps_pkg::COST_W-1:0] in_cost,
  input  wire logic [wrps_pkg::RND_W-1:0]                      in_rnd,
  output logic                                                 out_valid,
  input  wire logic                                            out_ready,
  output wrps_pkg::divw_t                                      out_data
);
  import wrps_pkg::*;

  localparam pmask_t LIM_MASK = pmask_t'((1 << USE_PORTS) - 1);

  logic   v_r;
  divw_t  st_r;
  divw_t  st_nxt;

  assign in_ready  = ~v_r | out_ready;
  assign out_valid = v_r;
  assign out_data  = st_r;

  always_comb begin
    logic [COST_W:0]   c;
    logic [PORT_W-1:0] pick;
    logic              none;
    logic              multi;
    st_nxt             = '0;
    st_nxt.ctl.present = in_present & LIM_MASK;
    st_nxt.ctl.vcok    = in_vc & st_nxt.ctl.present;
    st_nxt.rnd         = in_rnd;
    pick               = '0;
    for (int i = 0; i < NUM_COST; i++) begin
      c = st_nxt.ctl.vcok[i] ? ({1'b0, in_cost[i]} + 1'b1) : '0;
      st_nxt.sum    = st_nxt.sum + SUM_W'(c);
      st_nxt.rem[i] = REM_W'(SCALE * c);
      if (st_nxt.ctl.present[i]) begin
        pick = PORT_W'(i);
      end
    end
    none  = (st_nxt.ctl.present == '0);
    multi = ((st_nxt.ctl.present & (st_nxt.ctl.present - 1'b1)) != '0);
    st_nxt.ctl.decided   = none | ~multi | (st_nxt.sum == '0);
    st_nxt.ctl.no_choice = none | (multi & (st_nxt.sum == '0));
    st_nxt.ctl.port      = (~none & ~multi) ? pick : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/wrps_weight_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrps_weight_div
// Restoring division of SCALE*(cost+1) by the cost sum in every lane, a few
// quotient bits per stage; the last stage also adds up the weights.
// ----------------------------------------------------------------------------
module wrps_weight_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire wrps_pkg::divw_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output wrps_pkg::modw_t     out_data
);
  import wrps_pkg::*;

  localparam int NS = DIV_STAGES;

  logic              v_r   [NS];
  logic              v_nxt [NS];
  divw_t             st_r  [NS];
  divw_t             st_nxt[NS];
  logic [NS:0]       adv;

  always_comb begin
    adv[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = ~v_r[s] | adv[s+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];

  always_comb begin
    out_data       = '0;
    out_data.ctl   = st_r[NS-1].ctl;
    out_data.rnd   = st_r[NS-1].rnd;
    out_data.wt    = st_r[NS-1].wt;
    out_data.total = st_r[NS-1].total;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int HI = int'(WT_W) - 1 - s * int'(DIV_STEPS);
    localparam int LO = (HI >= int'(DIV_STEPS) - 1) ? HI - int'(DIV_STEPS) + 1 : 0;

    divw_t src;

    if (s == 0) begin : g_first
      assign src      = in_data;
      assign v_nxt[s] = in_valid;
    end else begin : g_next
      assign src      = st_r[s-1];
      assign v_nxt[s] = v_r[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] dvs;
      st_nxt[s] = src;
      for (int k = HI; k >= LO; k--) begin
        for (int i = 0; i < NUM_COST; i++) begin
          dvs = REM_W'(src.sum) << k;
          if (st_nxt[s].rem[i] >= dvs) begin
            st_nxt[s].rem[i]   = st_nxt[s].rem[i] - dvs;
            st_nxt[s].wt[i][k] = 1'b1;
          end
        end
      end
      if (s == NS - 1) begin
        st_nxt[s].total = '0;
        for (int i = 0; i < NUM_COST; i++) begin
          st_nxt[s].total = st_nxt[s].total + TOT_W'(st_nxt[s].wt[i]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv[s]) begin
        v_r[s] <= v_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/wrps_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrps_mod
// Reduces the random value modulo the weight total, one remainder bit per
// step and up to MOD_STEPS steps per stage.
// ----------------------------------------------------------------------------
module wrps_mod (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire wrps_pkg::modw_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output wrps_pkg::modw_t     out_data
);
  import wrps_pkg::*;

  localparam int NS = MOD_STAGES;

  logic              v_r   [NS];
  logic              v_nxt [NS];
  modw_t             st_r  [NS];
  modw_t             st_nxt[NS];
  logic [NS:0]       adv;

  always_comb begin
    adv[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = ~v_r[s] | adv[s+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];
  assign out_data  = st_r[NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int HI = int'(RND_W) - 1 - s * int'(MOD_STEPS);
    localparam int LO = (HI >= int'(MOD_STEPS) - 1) ? HI - int'(MOD_STEPS) + 1 : 0;

    modw_t src;

    if (s == 0) begin : g_first
      assign src      = in_data;
      assign v_nxt[s] = in_valid;
    end else begin : g_next
      assign src      = st_r[s-1];
      assign v_nxt[s] = v_r[s-1];
    end

    always_comb begin
      logic [TOT_W:0] r;
      st_nxt[s] = src;
      for (int k = HI; k >= LO; k--) begin
        r = {st_nxt[s].rem, src.rnd[k]};
        if (r >= {1'b0, src.total}) begin
          r = r - {1'b0, src.total};
        end
        st_nxt[s].rem = r[TOT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv[s]) begin
        v_r[s] <= v_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/wrps_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrps_select
// Walks the cumulative weights in port order and registers the chosen port.
// ----------------------------------------------------------------------------
module wrps_select (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire wrps_pkg::modw_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output wrps_pkg::res_t      out_data
);
  import wrps_pkg::*;

  logic  v_r;
  res_t  res_r;
  res_t  res_nxt;

  assign in_ready  = ~v_r | out_ready;
  assign out_valid = v_r;
  assign out_data  = res_r;

  always_comb begin
    logic [TOT_W-1:0] cum;
    logic             found;
    cum     = '0;
    found   = 1'b0;
    res_nxt = '0;
    for (int i = 0; i < NUM_COST; i++) begin
      if (in_data.ctl.present[i]) begin
        cum = cum + TOT_W'(in_data.wt[i]);
        if (!found && (in_data.rem < cum)) begin
          found        = 1'b1;
          res_nxt.port = PORT_W'(i);
        end
      end
    end
    if (in_data.ctl.decided) begin
      res_nxt.port      = in_data.ctl.port;
      res_nxt.no_choice = in_data.ctl.no_choice;
    end else if ((in_data.total == '0) || !found) begin
      res_nxt.port      = '0;
      res_nxt.no_choice = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/weighted_random_port_select.sv =====
// Pipeline: an accepted request passes 1 front stage, 3 weight-division stages,
// 4 modulo stages and 1 selection stage. Throughput: one request per cycle
// unless the output stalls; the modulo stages, up to 8 remainder bits each over
// 31 bits, set the pipeline depth. A stalled output holds only the stages behind it.
// Reset: synchronous, active low; it empties the pipeline, no other state.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_random_port_select
// Router output-port selector using a weighted random (roulette wheel) draw.
// ----------------------------------------------------------------------------
//
// Every request names the candidate ports, those with a free virtual channel,
// a cost per port and a random value. A lone candidate is taken outright,
// even without a free channel. Otherwise each candidate with a free channel
// is given the weight floor(100*(cost+1)/S), S being the sum of (cost+1)
// over those ports, and the random value reduced modulo the weight total
// picks the lowest port whose running sum of weights lies above it.
//
// The request flows through a chain of handshaked register stages. Each
// stage takes new data whenever it is empty or the stage after it moves on,
// so bubbles close up behind a stalled output and no request is dropped or
// repeated. The weight division is a restoring divider spread over three
// stages (quotient bits 6..4, 3..1 and 0, the last stage also summing the
// weights), and the modulo reduction is a bit-serial restoring remainder
// spread over four stages.
//
// Ports at or above NUM_PORTS, and any beyond the five that carry a cost,
// are never considered.
module weighted_random_port_select #(
  parameter int unsigned NUM_PORTS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_port_present_mask,
  input  wire logic [4:0]  in_port_vc_mask,
  input  wire logic [7:0]  in_cost_port0,
  input  wire logic [7:0]  in_cost_port1,
  input  wire logic [7:0]  in_cost_port2,
  input  wire logic [7:0]  in_cost_port3,
  input  wire logic [7:0]  in_cost_port4,
  input  wire logic [30:0] in_random_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_chosen_port,
  output logic             out_no_choice
);
  import wrps_pkg::*;

  // Only ports that exist and carry a cost take part.
  localparam int unsigned USE_PORTS = (NUM_PORTS < NUM_COST) ? NUM_PORTS : NUM_COST;

  logic [NUM_COST-1:0][COST_W-1:0] cost_all;

  logic   fr_valid;
  logic   fr_ready;
  divw_t  fr_data;
  logic   dv_valid;
  logic   dv_ready;
  modw_t  dv_data;
  logic   md_valid;
  logic   md_ready;
  modw_t  md_data;
  res_t   res;

  assign cost_all = {in_cost_port4, in_cost_port3, in_cost_port2,
                     in_cost_port1, in_cost_port0};

  // Candidate masking, scaled costs, their sum and the trivial outcomes.
  wrps_front #(
    .USE_PORTS (USE_PORTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_present (in_port_present_mask),
    .in_vc      (in_port_vc_mask),
    .in_cost    (cost_all),
    .in_rnd     (in_random_value),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .out_data   (fr_data)
  );

  // Per-port weights and their total.
  wrps_weight_div u_weight_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  // Random value reduced modulo the weight total.
  wrps_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .out_valid (md_valid),
    .out_ready (md_ready),
    .out_data  (md_data)
  );

  // Roulette walk and the output register.
  wrps_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (md_valid),
    .in_ready  (md_ready),
    .in_data   (md_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign out_chosen_port = res.port;
  assign out_no_choice   = res.no_choice;

endmodule
`default_nettype wire

// ===== verif/tb_weighted_random_port_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_random_port_select
// Self-checking bench for the weighted random output-port selector.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready channel and every accepted one is
// predicted at once by a bit-true integer model of the roulette wheel draw.
// Results are matched in order against the predictions. A directed set
// covers the corner cases, then about 1900 random requests follow, with
// random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------

import wrps_pkg::*;

typedef struct packed {
  pmask_t                            present;
  pmask_t                            vcok;
  logic [NUM_COST-1:0][COST_W-1:0]   cost;
  logic [RND_W-1:0]                  rnd;
} port_request_t;

class port_pick_board;
  int unsigned nports;
  res_t        picks_due[$];
  int unsigned mismatch_count;

  function new(int unsigned num_ports);
    nports         = (num_ports < NUM_COST) ? num_ports : NUM_COST;
    mismatch_count = 0;
  endfunction

  // Roulette wheel draw in plain unsigned integer arithmetic.
  function res_t predict_pick(port_request_t r);
    res_t        res;
    pmask_t      cand;
    pmask_t      free;
    int unsigned count;
    int unsigned wsum;
    int unsigned total;
    int unsigned cum;
    int unsigned draw;
    int unsigned wt [NUM_COST];
    int unsigned lone;
    bit          done;

    res   = '0;
    cand  = r.present & pmask_t'((1 << nports) - 1);
    free  = r.vcok & cand;
    count = 0;
    wsum  = 0;
    total = 0;
    cum   = 0;
    lone  = 0;
    done  = 1'b0;
    for (int i = 0; i < NUM_COST; i++) begin
      wt[i] = 0;
      if (cand[i]) begin
        count++;
        lone = i;
      end
      if (free[i]) wsum += int'(r.cost[i]) + 1;
    end

    if (count == 0) begin
      res.no_choice = 1'b1;
    end else if (count == 1) begin
      // A lone candidate wins whether or not it has a free channel.
      res.port = PORT_W'(lone);
    end else if (wsum == 0) begin
      res.no_choice = 1'b1;
    end else begin
      for (int i = 0; i < NUM_COST; i++) begin
        if (free[i]) wt[i] = (SCALE * (int'(r.cost[i]) + 1)) / wsum;
        total += wt[i];
      end
      if (total == 0) begin
        res.no_choice = 1'b1;
      end else begin
        draw = r.rnd % total;
        for (int i = 0; i < NUM_COST; i++) begin
          if (cand[i] && !done) begin
            cum += wt[i];
            if (draw < cum) begin
              res.port = PORT_W'(i);
              done     = 1'b1;
            end
          end
        end
        if (!done) res.no_choice = 1'b1;
      end
    end
    return res;
  endfunction

  function void note_request(port_request_t r);
    picks_due.push_back(predict_pick(r));
  endfunction

  function void check_pick(logic [PORT_W-1:0] port, logic no_choice);
    res_t want;
    if (picks_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: port %0d no_choice %0b with nothing pending",
                 port, no_choice);
    end else begin
      want = picks_due.pop_front();
      if (port !== want.port || no_choice !== want.no_choice) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected port %0d no_choice %0b, got port %0d no_choice %0b",
                   want.port, want.no_choice, port, no_choice);
      end
    end
  endfunction

  function int unsigned outstanding();
    return picks_due.size();
  endfunction

  function bit clean();
    return mismatch_count == 0 && picks_due.size() == 0;
  endfunction
endclass

module tb_weighted_random_port_select;

  localparam int unsigned NUM_PORTS    = 5;
  localparam int unsigned RANDOM_COUNT = 1875;
  // Nine pipeline stages; the drain wait covers any stray result.
  localparam int unsigned DRAIN_CYCLES = 24;
  // This limit is very generous for a correct run.
  localparam int unsigned CYCLE_LIMIT  = 100000;

  // Receiver schedule, counted in cycles after reset: one long hold-off so
  // that the pipeline fills and pushes back on the sender, and one calm
  // window with no stalls at all.
  localparam int unsigned HOLD_FROM  = 300;
  localparam int unsigned HOLD_TO    = 500;
  localparam int unsigned CALM_FROM  = 1200;
  localparam int unsigned CALM_TO    = 1800;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_port_present_mask;
  logic [4:0]  in_port_vc_mask;
  logic [7:0]  in_cost_port0;
  logic [7:0]  in_cost_port1;
  logic [7:0]  in_cost_port2;
  logic [7:0]  in_cost_port3;
  logic [7:0]  in_cost_port4;
  logic [30:0] in_random_value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_chosen_port;
  logic        out_no_choice;

  port_pick_board board = new(NUM_PORTS);
  int unsigned    cycle_count = 0;
  bit             sender_gaps = 1'b1;

  weighted_random_port_select #(
    .NUM_PORTS(NUM_PORTS)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_port_present_mask(in_port_present_mask),
    .in_port_vc_mask     (in_port_vc_mask),
    .in_cost_port0       (in_cost_port0),
    .in_cost_port1       (in_cost_port1),
    .in_cost_port2       (in_cost_port2),
    .in_cost_port3       (in_cost_port3),
    .in_cost_port4       (in_cost_port4),
    .in_random_value     (in_random_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_chosen_port     (out_chosen_port),
    .out_no_choice       (out_no_choice)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every result taken at an edge is checked against the oldest prediction.
  // Signals are read just after the edge, so they hold the values that the
  // block itself saw at that edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_pick(out_chosen_port, out_no_choice);
  end

  // Receiver: random stalls in about one cycle in seven, apart from the
  // hold-off and the calm window.
  initial begin
    int unsigned rx_cycle;
    rx_cycle  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) rx_cycle++;
      if (!rst_n || (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_TO))
        out_ready <= 1'b0;
      else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_TO)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= 14);
    end
  end

  function automatic port_request_t make_request(
    input pmask_t present, input pmask_t vcok,
    input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
    input logic [7:0] c3, input logic [7:0] c4, input logic [30:0] rnd
  );
    port_request_t r;
    r.present = present;
    r.vcok    = vcok;
    r.cost    = {c4, c3, c2, c1, c0};
    r.rnd     = rnd;
    return r;
  endfunction

  // Random requests lean towards the interesting shapes: empty and one-hot
  // candidate sets, channel masks that are all clear or all set, costs at
  // their extremes and draws near either end of the range.
  function automatic port_request_t random_request();
    port_request_t r;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      r.present = '0;
    else if (pick < 20)
      r.present = pmask_t'(1 << $urandom_range(0, NUM_COST - 1));
    else
      r.present = pmask_t'($urandom());
    pick = $urandom_range(0, 9);
    if (pick == 0)
      r.vcok = '0;
    else if (pick == 1)
      r.vcok = '1;
    else
      r.vcok = pmask_t'($urandom());
    for (int i = 0; i < NUM_COST; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        r.cost[i] = 8'd0;
      else if (pick == 1)
        r.cost[i] = 8'd255;
      else if (pick == 2)
        r.cost[i] = 8'($urandom_range(0, 7));
      else
        r.cost[i] = 8'($urandom());
    end
    pick = $urandom_range(0, 9);
    if (pick == 0)
      r.rnd = 31'($urandom_range(0, 255));
    else if (pick == 1)
      r.rnd = 31'h7FFF_FFFF - 31'($urandom_range(0, 255));
    else
      r.rnd = 31'($urandom());
    return r;
  endfunction

  // Offers one request and returns once it has been accepted. A gap, if one
  // is drawn, drops valid and waits on the clock before the request is
  // raised, so valid never falls and rises within one step.
  task automatic offer_request(input port_request_t r);
    if (sender_gaps && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid             <= 1'b1;
    in_port_present_mask <= r.present;
    in_port_vc_mask      <= r.vcok;
    in_cost_port0        <= r.cost[0];
    in_cost_port1        <= r.cost[1];
    in_cost_port2        <= r.cost[2];
    in_cost_port3        <= r.cost[3];
    in_cost_port4        <= r.cost[4];
    in_random_value      <= r.rnd;
    do @(posedge clk); while (!in_ready);
    board.note_request(r);
  endtask

  task automatic run_directed();
    // No candidate at all, with and without free channels.
    offer_request(make_request(5'h00, 5'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 31'd0));
    offer_request(make_request(5'h00, 5'h1F, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                               31'h7FFF_FFFF));
    // A lone candidate is taken even when it has no free channel.
    for (int i = 0; i < NUM_COST; i++)
      offer_request(make_request(pmask_t'(1 << i), 5'h00, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
                                 31'h5555_5555));
    offer_request(make_request(5'h10, 5'h1F, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 31'd3));
    // Several candidates but none with a free channel: weight total is zero.
    offer_request(make_request(5'h03, 5'h00, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 31'd17));
    offer_request(make_request(5'h1F, 5'h00, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                               31'd0));
    // Free-channel bits outside the candidate set must be ignored.
    offer_request(make_request(5'h05, 5'h1A, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 31'd42));
    offer_request(make_request(5'h06, 5'h19, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 31'd1));
    // Equal weights of twenty, draws at the edges of the wheel.
    offer_request(make_request(5'h1F, 5'h1F, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 31'd0));
    offer_request(make_request(5'h1F, 5'h1F, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 31'd99));
    offer_request(make_request(5'h1F, 5'h1F, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                               31'd100));
    offer_request(make_request(5'h1F, 5'h1F, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                               31'h7FFF_FFFF));
    // One dominant port; the others floor to zero weight and can never win.
    offer_request(make_request(5'h1F, 5'h1F, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 31'd0));
    offer_request(make_request(5'h1F, 5'h1F, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 31'd97));
    // Candidates without a free channel sit between weighted ones.
    offer_request(make_request(5'h1F, 5'h11, 8'd255, 8'd7, 8'd7, 8'd7, 8'd0, 31'd99));
    offer_request(make_request(5'h1F, 5'h0A, 8'd0, 8'd128, 8'd0, 8'd127, 8'd0,
                               31'h7FFF_FFFE));
    // Alternating bit patterns in the costs and the draw.
    offer_request(make_request(5'h15, 5'h15, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                               31'h2AAA_AAAA));
    offer_request(make_request(5'h0A, 5'h0A, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                               31'h5555_5555));
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_port_present_mask <= '0;
    in_port_vc_mask      <= '0;
    in_cost_port0        <= '0;
    in_cost_port1        <= '0;
    in_cost_port2        <= '0;
    in_cost_port3        <= '0;
    in_cost_port4        <= '0;
    in_random_value      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // The middle stretch of random requests goes in back to back.
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      sender_gaps = !(n >= 900 && n < 1300);
      offer_request(random_request());
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then wait out the drain time so that any
    // surplus result would still be caught.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.clean())
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/wrps_pkg.sv
design/wrps_front.sv
design/wrps_weight_div.sv
design/wrps_mod.sv
design/wrps_select.sv
design/weighted_random_port_select.sv
verif/tb_weighted_random_port_select.sv
